/* hw/rtl/mmpa_pkg.sv */
// Shared constants, types and helpers of the masked min-plus assignment block.
package mmpa_pkg;

	// Table geometry
	localparam int MAX_STATES = 8;
	localparam int SET_W      = 8;
	localparam int EFF_MAX    = (MAX_STATES < SET_W) ? MAX_STATES : SET_W;
	localparam int CNT_W      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
	localparam int TBL_DEPTH  = MAX_STATES * MAX_STATES;
	localparam int ADDR_W     = $clog2(TBL_DEPTH);

	// Field widths
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 3;
	localparam int COST_W     = 32;
	localparam int SUM_W      = 33;
	localparam int SIZE_W     = 4;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
	localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_FIRST  = 2'd0,
		CMD_WR_SECOND = 2'd1,
		CMD_QUERY     = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_SIZE = 1'b0,
		REG_TIE_TOL     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Control into the best-cost tracker
	typedef struct packed {
		logic             clr;
		logic             upd;
		logic [CNT_W-1:0] k;
	} trk_ctl_t;

	// Flat table address of entry [r][c]
	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		int a;
		a = int'(r) * MAX_STATES + int'(c);
		return ADDR_W'(a);
	endfunction

endpackage

/* hw/rtl/mmpa_req_if.sv */
// Request channel: table writes and queries.
interface mmpa_req_if;
	logic                           valid;
	logic                           ready;
	logic [mmpa_pkg::CMD_W-1:0]     cmd;
	logic [mmpa_pkg::IDX_W-1:0]     row;
	logic [mmpa_pkg::IDX_W-1:0]     col;
	logic [mmpa_pkg::COST_W-1:0]    entry_cost;
	logic [mmpa_pkg::SET_W-1:0]     x_set;
	logic [mmpa_pkg::SET_W-1:0]     y_set;

	modport source (output valid, cmd, row, col, entry_cost, x_set, y_set, input ready);
	modport sink   (input valid, cmd, row, col, entry_cost, x_set, y_set, output ready);
endinterface

/* hw/rtl/mmpa_rsp_if.sv */
// Response channel: query results.
interface mmpa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mmpa_pkg::SUM_W-1:0]   min_cost;
	logic [mmpa_pkg::SET_W-1:0]   assign_set;
	logic                         empty_query;

	modport source (output valid, min_cost, assign_set, empty_query, input ready);
	modport sink   (input valid, min_cost, assign_set, empty_query, output ready);
endinterface

/* hw/rtl/masked_min_plus_assign_core.sv */
// Masked min-plus assignment core: two cost tables in RAM and a query sequencer.
//
//  channel  dir  handshake         payload
//  req      in   valid/ready       cmd, row, col, entry_cost, x_set, y_set
//  rsp      out  valid/ready       min_cost, assign_set, empty_query
//  cfg      in   cfg_we            cfg_index, cfg_wdata
//
// A query evaluates one sum per cycle over its selected (i,j) pairs, since each
// table has a single read port; each unselected pair is passed without a sum,
// and the query then drains the pipeline and loads the result. The tables hold
// unknown data after reset; no clearing. A new request is taken while the
// previous result still waits on rsp; a stalled rsp holds a finished query
// until the output register frees up.
module masked_min_plus_assign_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	mmpa_req_if.sink                         req,
	mmpa_rsp_if.source                       rsp
);

	logic [mmpa_pkg::SIZE_W-1:0]  size_q;
	logic [mmpa_pkg::TOL_W-1:0]   tol_q;
	logic [mmpa_pkg::SIZE_W-1:0]  n_eff;
	logic [mmpa_pkg::SET_W-1:0]   act_mask;
	logic [mmpa_pkg::SET_W-1:0]   xs_m;
	logic [mmpa_pkg::SET_W-1:0]   ys_m;
	logic                         q_empty;

	logic                         req_acc;
	logic                         query_acc;
	logic                         wr_in_range;
	logic                         wr_first;
	logic                         wr_second;
	logic [mmpa_pkg::ADDR_W-1:0]  wr_addr;

	mmpa_pkg::state_t             state_q;
	mmpa_pkg::state_t             state_d;
	logic [mmpa_pkg::SET_W-1:0]   xs_q;
	logic [mmpa_pkg::SET_W-1:0]   ys_q;
	logic [mmpa_pkg::CNT_W-1:0]   nm1_q;
	logic                         empty_q;
	logic [mmpa_pkg::CNT_W-1:0]   i_q;
	logic [mmpa_pkg::CNT_W-1:0]   j_q;
	logic [mmpa_pkg::CNT_W-1:0]   k_q;
	logic                         pair_sel;
	logic                         pair_end;
	logic                         last_pair;
	logic                         issue;
	logic                         out_free;
	logic                         out_load;
	logic [mmpa_pkg::ADDR_W-1:0]  rd_addr_x;
	logic [mmpa_pkg::ADDR_W-1:0]  rd_addr_y;

	logic [mmpa_pkg::COST_W-1:0]  mem_x [mmpa_pkg::TBL_DEPTH];
	logic [mmpa_pkg::COST_W-1:0]  mem_y [mmpa_pkg::TBL_DEPTH];

	logic                         vld_s1;
	logic [mmpa_pkg::CNT_W-1:0]   k_s1;
	logic [mmpa_pkg::COST_W-1:0]  x_s1;
	logic [mmpa_pkg::COST_W-1:0]  y_s1;
	logic                         vld_s2;
	logic [mmpa_pkg::CNT_W-1:0]   k_s2;
	logic [mmpa_pkg::SUM_W-1:0]   sum_s2;

	mmpa_pkg::trk_ctl_t           trk_ctl;
	logic [mmpa_pkg::SUM_W-1:0]   trk_best;
	logic [mmpa_pkg::SET_W-1:0]   trk_assign;

	logic                         rsp_vld_q;
	logic [mmpa_pkg::SUM_W-1:0]   min_cost_q;
	logic [mmpa_pkg::SET_W-1:0]   assign_set_q;
	logic                         empty_query_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mmpa_pkg::SIZE_RESET;
			tol_q  <= mmpa_pkg::TOL_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mmpa_pkg::REG_ACTIVE_SIZE) begin
				size_q <= cfg_wdata[mmpa_pkg::SIZE_W-1:0];
			end else if (cfg_index == mmpa_pkg::REG_TIE_TOL) begin
				tol_q <= cfg_wdata[mmpa_pkg::TOL_W-1:0];
			end
		end
	end

	// Effective size and masked query sets
	always_comb begin
		n_eff = (size_q > mmpa_pkg::SIZE_W'(mmpa_pkg::EFF_MAX)) ?
			mmpa_pkg::SIZE_W'(mmpa_pkg::EFF_MAX) : size_q;
		for (int b = 0; b < mmpa_pkg::SET_W; b++) begin
			act_mask[b] = mmpa_pkg::SIZE_W'(b) < n_eff;
		end
		xs_m    = req.x_set & act_mask;
		ys_m    = req.y_set & act_mask;
		q_empty = (xs_m == '0) || (ys_m == '0);
	end

	// Decode the accepted request
	always_comb begin
		req_acc     = req.valid && req.ready;
		wr_in_range = (int'(req.row) < mmpa_pkg::MAX_STATES) &&
			(int'(req.col) < mmpa_pkg::MAX_STATES);
		wr_addr     = mmpa_pkg::tbl_addr(req.row, req.col);
		wr_first    = req_acc && wr_in_range && (req.cmd == mmpa_pkg::CMD_WR_FIRST);
		wr_second   = req_acc && wr_in_range && (req.cmd == mmpa_pkg::CMD_WR_SECOND);
		query_acc   = req_acc && (req.cmd == mmpa_pkg::CMD_QUERY);
	end

	// Sequencer status
	always_comb begin
		pair_sel  = xs_q[i_q] && ys_q[j_q];
		pair_end  = !pair_sel || (k_q == nm1_q);
		last_pair = (i_q == nm1_q) && (j_q == nm1_q);
		out_free  = !rsp_vld_q || rsp.ready;
		rd_addr_x = mmpa_pkg::tbl_addr(mmpa_pkg::IDX_W'(i_q), mmpa_pkg::IDX_W'(k_q));
		rd_addr_y = mmpa_pkg::tbl_addr(mmpa_pkg::IDX_W'(j_q), mmpa_pkg::IDX_W'(k_q));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmpa_pkg::ST_IDLE: begin
				if (query_acc) begin
					state_d = q_empty ? mmpa_pkg::ST_DONE : mmpa_pkg::ST_RUN;
				end
			end
			mmpa_pkg::ST_RUN: begin
				if (pair_end && last_pair) begin
					state_d = mmpa_pkg::ST_DRAIN;
				end
			end
			mmpa_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = mmpa_pkg::ST_DONE;
				end
			end
			mmpa_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mmpa_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// State outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			mmpa_pkg::ST_IDLE:  req.ready = 1'b1;
			mmpa_pkg::ST_RUN:   issue     = pair_sel;
			mmpa_pkg::ST_DRAIN: ;
			mmpa_pkg::ST_DONE:  out_load  = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the query and advance the i, j, k walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (query_acc) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (state_q == mmpa_pkg::ST_RUN) begin
			if (!pair_end) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
				if (j_q != nm1_q) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			xs_q    <= xs_m;
			ys_q    <= ys_m;
			nm1_q   <= mmpa_pkg::CNT_W'(n_eff - 1'b1);
			empty_q <= q_empty;
		end
	end

	// Cost tables: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_first) begin
			mem_x[wr_addr] <= req.entry_cost;
		end
		x_s1 <= mem_x[rd_addr_x];
	end

	always_ff @(posedge clk) begin
		if (wr_second) begin
			mem_y[wr_addr] <= req.entry_cost;
		end
		y_s1 <= mem_y[rd_addr_y];
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	// Middle index follows the read; add the two costs
	always_ff @(posedge clk) begin
		k_s1   <= k_q;
		k_s2   <= k_s1;
		sum_s2 <= {1'b0, x_s1} + {1'b0, y_s1};
	end

	assign trk_ctl = '{clr: query_acc, upd: vld_s2, k: k_s2};

	mmpa_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (trk_ctl),
		.sum        (sum_s2),
		.tol        (tol_q),
		.best       (trk_best),
		.assign_set (trk_assign)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			min_cost_q    <= empty_q ? '0 : trk_best;
			assign_set_q  <= empty_q ? '0 : trk_assign;
			empty_query_q <= empty_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.min_cost    = min_cost_q;
	assign rsp.assign_set  = assign_set_q;
	assign rsp.empty_query = empty_query_q;

	// Sums reach the tracker only while a query is in flight
	a_upd_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == mmpa_pkg::ST_RUN || state_q == mmpa_pkg::ST_DRAIN))
		else $error("tracker update outside a query");

	// The walk stays inside the active size
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmpa_pkg::ST_RUN) |-> (i_q <= nm1_q && j_q <= nm1_q && k_q <= nm1_q))
		else $error("walk index beyond active size");

	// A finished query shows up on rsp in the next cycle
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (rsp.valid && state_q == mmpa_pkg::ST_IDLE))
		else $error("finished query not presented");

	// A non-empty result names at least one middle state
	a_assign_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.empty_query) |-> (rsp.assign_set != '0))
		else $error("non-empty result without assignment");

endmodule

/* hw/rtl/mmpa_track.sv */
// Running best-sum tracker with tie tolerance and middle-state bitset.
module mmpa_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mmpa_pkg::trk_ctl_t          ctl,
	input  logic [mmpa_pkg::SUM_W-1:0]  sum,
	input  logic [mmpa_pkg::TOL_W-1:0]  tol,
	output logic [mmpa_pkg::SUM_W-1:0]  best,
	output logic [mmpa_pkg::SET_W-1:0]  assign_set
);

	logic                        have_q;
	logic [mmpa_pkg::SUM_W-1:0]  best_q;
	logic [mmpa_pkg::SET_W-1:0]  assign_q;
	logic [mmpa_pkg::SUM_W-1:0]  diff;
	logic                        lower;
	logic                        tie;
	logic [mmpa_pkg::SET_W-1:0]  k_bit;

	// Compare the new sum with the running best
	always_comb begin
		lower = sum < best_q;
		diff  = lower ? (best_q - sum) : (sum - best_q);
		tie   = have_q && (diff < mmpa_pkg::SUM_W'(tol));
		k_bit = mmpa_pkg::SET_W'(1) << ctl.k;
	end

	// Track whether any sum has been seen for this query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clr) begin
			have_q <= 1'b0;
		end else if (ctl.upd) begin
			have_q <= 1'b1;
		end
	end

	// Fold the sum into best and assignment set
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			assign_q <= '0;
		end else if (ctl.upd) begin
			if (tie) begin
				if (lower) begin
					best_q <= sum;
				end
				assign_q <= assign_q | k_bit;
			end else if (!have_q || lower) begin
				best_q   <= sum;
				assign_q <= k_bit;
			end
		end
	end

	assign best       = best_q;
	assign assign_set = assign_q;

endmodule
